>>> sv/qau_pkg.sv
// Shared types, command codes and saturation helper for the quaternion unit.
package qau_pkg;

    localparam int DATA_W        = 32;
    localparam int LANES         = 4;
    localparam int ACC_W         = 66;
    localparam int DEN_W         = 65;
    localparam int QBITS         = 33;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [LANES-1:0][DATA_W-1:0] quat_t;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_PROD  = 4'd2,
        CMD_CONJ  = 4'd3,
        CMD_NEG   = 4'd4,
        CMD_SCALE = 4'd5,
        CMD_DIV   = 4'd6,
        CMD_RECIP = 4'd7,
        CMD_NORM  = 4'd8
    } cmd_t;

    // Hamilton product: term t of lane l is a[t]*b[l^t], subtracted where set
    localparam logic [LANES-1:0][LANES-1:0] PROD_MINUS =
        {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    typedef struct packed {
        logic [3:0]                        cmd;
        quat_t                             simple;
        logic [LANES-1:0][ACC_W-1:0]       acc;
        quat_t                             mag;
        logic [LANES-1:0]                  neg;
        word_t                             fmag;
        logic                              fault;
    } front_word_t;

    typedef struct packed {
        logic                              is_div;
        logic                              fault;
        quat_t                             res;
        logic [DEN_W-1:0]                  den;
        logic [LANES-1:0][DEN_W-1:0]       rem;
        logic [LANES-1:0][QBITS-1:0]       nq;
        logic [LANES-1:0]                  neg;
        logic [LANES-1:0]                  ovf;
    } div_word_t;

    // sign and magnitude to a saturated 32-bit two's complement word
    function automatic word_t sat_pack(input logic neg, input logic [ACC_W-1:0] m);
        word_t r;
        if (!neg) begin
            r = (m > 66'h7FFFFFFF) ? 32'h7FFFFFFF : m[DATA_W-1:0];
        end
        else begin
            r = (m > 66'h80000000) ? 32'h80000000 : (~m[DATA_W-1:0] + 32'd1);
        end
        return r;
    endfunction

endpackage

>>> sv/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit, signed fixed point, fully pipelined.
//
// Input channel: in_valid/in_ready with command, quaternions a and b, and
// factor. Output channel: out_valid/out_ready with r_real, r_i, r_j, r_k and
// fault. Every accepted item produces exactly one result item, in order.
//
// Every command passes from acceptance to out_valid through five front
// stages (capture, operand select, multiply, two adder levels), two divider
// setup stages, 33 restoring-division stages (one quotient bit each, four
// lanes in parallel), and the output register. All commands travel the
// same pipeline so order is kept.
// Throughput is one item per cycle while out_ready is high. Each stage holds
// a valid bit and advances when the stage after it is empty or moving, so
// bubbles close up and a new item is taken while the output holds a result.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver holds out_ready low, the result stays on the output and
// items queue in the stages behind it; in_ready drops once all are full.
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          command,
    input  qau_pkg::word_t      a_real,
    input  qau_pkg::word_t      a_i,
    input  qau_pkg::word_t      a_j,
    input  qau_pkg::word_t      a_k,
    input  qau_pkg::word_t      b_real,
    input  qau_pkg::word_t      b_i,
    input  qau_pkg::word_t      b_j,
    input  qau_pkg::word_t      b_k,
    input  qau_pkg::word_t      factor,
    output logic                out_valid,
    input  logic                out_ready,
    output qau_pkg::word_t      r_real,
    output qau_pkg::word_t      r_i,
    output qau_pkg::word_t      r_j,
    output qau_pkg::word_t      r_k,
    output logic                fault
);
    import qau_pkg::*;

    quat_t       a_q, b_q, r_q;
    logic        mid_valid, mid_ready;
    front_word_t mid_word;

    assign a_q = {a_k, a_j, a_i, a_real};
    assign b_q = {b_k, b_j, b_i, b_real};

    qau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .a         (a_q),
        .b         (b_q),
        .factor    (factor),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_word  (mid_word)
    );

    qau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_word   (mid_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .r         (r_q),
        .fault     (fault)
    );

    assign r_real = r_q[0];
    assign r_i    = r_q[1];
    assign r_j    = r_q[2];
    assign r_k    = r_q[3];

endmodule

>>> sv/qau_front.sv
// Front pipeline: operand capture, simple ops, multiplier array and term sums.
module qau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          command,
    input  qau_pkg::quat_t      a,
    input  qau_pkg::quat_t      b,
    input  qau_pkg::word_t      factor,
    output logic                out_valid,
    input  logic                out_ready,
    output qau_pkg::front_word_t out_word
);
    import qau_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    logic [3:0]  cmd1_reg;
    quat_t       a1_reg, b1_reg;
    word_t       f1_reg;

    front_word_t carry2_next, carry2_reg, carry3_reg, carry4_reg, f5_next, f5_reg;

    logic signed [DATA_W-1:0] x2_next [LANES][LANES];
    logic signed [DATA_W-1:0] y2_next [LANES][LANES];
    logic                     minus2_next [LANES][LANES];
    logic signed [DATA_W-1:0] x2_reg [LANES][LANES];
    logic signed [DATA_W-1:0] y2_reg [LANES][LANES];
    logic                     minus2_reg [LANES][LANES];

    logic signed [2*DATA_W-1:0] p3_reg [LANES][LANES];
    logic                       minus3_reg [LANES][LANES];

    logic signed [ACC_W-1:0] s4_next [LANES][2];
    logic signed [ACC_W-1:0] s4_reg [LANES][2];

    function automatic word_t sat33(input logic [DATA_W:0] v);
        word_t r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? 32'h80000000 : 32'h7FFFFFFF;
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] term(input logic signed [2*DATA_W-1:0] p,
                                                     input logic m);
        logic signed [ACC_W-1:0] e;
        e = p;
        return m ? -e : e;
    endfunction

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v5_reg;
    assign out_word  = f5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // operand selection and add/sub/conjugate/negate
    always_comb
    begin
        carry2_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            for (int t = 0; t < LANES; t++)
            begin
                x2_next[l][t]     = '0;
                y2_next[l][t]     = '0;
                minus2_next[l][t] = 1'b0;
            end
        end
        carry2_next.cmd  = cmd1_reg;
        carry2_next.fmag = f1_reg[DATA_W-1] ? (~f1_reg + 32'd1) : f1_reg;
        for (int l = 0; l < LANES; l++)
        begin
            carry2_next.mag[l] = a1_reg[l][DATA_W-1] ? (~a1_reg[l] + 32'd1) : a1_reg[l];
        end
        unique case (cmd1_reg)
            CMD_ADD:
                for (int l = 0; l < LANES; l++)
                    carry2_next.simple[l] = sat33({a1_reg[l][DATA_W-1], a1_reg[l]}
                                                + {b1_reg[l][DATA_W-1], b1_reg[l]});
            CMD_SUB:
                for (int l = 0; l < LANES; l++)
                    carry2_next.simple[l] = sat33({a1_reg[l][DATA_W-1], a1_reg[l]}
                                                - {b1_reg[l][DATA_W-1], b1_reg[l]});
            CMD_CONJ:
            begin
                carry2_next.simple[0] = a1_reg[0];
                for (int l = 1; l < LANES; l++)
                    carry2_next.simple[l] = sat33(33'd0 - {a1_reg[l][DATA_W-1], a1_reg[l]});
            end
            CMD_NEG:
                for (int l = 0; l < LANES; l++)
                    carry2_next.simple[l] = sat33(33'd0 - {a1_reg[l][DATA_W-1], a1_reg[l]});
            CMD_PROD:
                for (int l = 0; l < LANES; l++)
                    for (int t = 0; t < LANES; t++)
                    begin
                        x2_next[l][t]     = $signed(a1_reg[t]);
                        y2_next[l][t]     = $signed(b1_reg[2'(l) ^ 2'(t)]);
                        minus2_next[l][t] = PROD_MINUS[l][t];
                    end
            CMD_SCALE:
                for (int l = 0; l < LANES; l++)
                begin
                    x2_next[l][0] = $signed(a1_reg[l]);
                    y2_next[l][0] = $signed(f1_reg);
                end
            CMD_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                    carry2_next.neg[l] = a1_reg[l][DATA_W-1] ^ f1_reg[DATA_W-1];
                carry2_next.fault = (f1_reg == '0);
            end
            CMD_RECIP:
            begin
                // squared norm in lane 0 feeds the divisor
                for (int t = 0; t < LANES; t++)
                begin
                    x2_next[0][t] = $signed(a1_reg[t]);
                    y2_next[0][t] = $signed(a1_reg[t]);
                end
                carry2_next.neg[0] = a1_reg[0][DATA_W-1];
                for (int l = 1; l < LANES; l++)
                    carry2_next.neg[l] = !a1_reg[l][DATA_W-1] && (a1_reg[l] != '0);
                carry2_next.fault = (a1_reg == '0);
            end
            CMD_NORM:
                for (int t = 0; t < LANES; t++)
                begin
                    x2_next[0][t] = $signed(a1_reg[t]);
                    y2_next[0][t] = $signed(a1_reg[t]);
                end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            s4_next[l][0] = term(p3_reg[l][0], minus3_reg[l][0])
                          + term(p3_reg[l][1], minus3_reg[l][1]);
            s4_next[l][1] = term(p3_reg[l][2], minus3_reg[l][2])
                          + term(p3_reg[l][3], minus3_reg[l][3]);
        end
    end

    always_comb
    begin
        f5_next = carry4_reg;
        for (int l = 0; l < LANES; l++)
            f5_next.acc[l] = s4_reg[l][0] + s4_reg[l][1];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cmd1_reg <= command;
            a1_reg   <= a;
            b1_reg   <= b;
            f1_reg   <= factor;
        end
        if (en2)
        begin
            carry2_reg <= carry2_next;
            x2_reg     <= x2_next;
            y2_reg     <= y2_next;
            minus2_reg <= minus2_next;
        end
        if (en3)
        begin
            carry3_reg <= carry2_reg;
            for (int l = 0; l < LANES; l++)
                for (int t = 0; t < LANES; t++)
                    p3_reg[l][t] <= x2_reg[l][t] * y2_reg[l][t];
            minus3_reg <= minus2_reg;
        end
        if (en4)
        begin
            carry4_reg <= carry3_reg;
            s4_reg     <= s4_next;
        end
        if (en5)
        begin
            f5_reg <= f5_next;
        end
    end

endmodule

>>> sv/qau_div_step.sv
// One restoring-division stage: one quotient bit per lane per item.
module qau_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qau_pkg::div_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output qau_pkg::div_word_t out_word
);
    import qau_pkg::*;

    logic      v_reg;
    logic      en;
    div_word_t w_next, w_reg;

    assign en        = !v_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg;
    assign out_word  = w_reg;

    always_comb
    begin
        w_next = in_word;
        for (int l = 0; l < LANES; l++)
        begin
            logic [DEN_W:0] rem2;
            logic [DEN_W:0] diff;
            logic           ge;
            rem2 = {in_word.rem[l], in_word.nq[l][QBITS-1]};
            diff = rem2 - {1'b0, in_word.den};
            ge   = rem2 >= {1'b0, in_word.den};
            w_next.rem[l] = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            w_next.nq[l]  = {in_word.nq[l][QBITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= w_next;
    end

endmodule

>>> sv/qau_div.sv
// Back pipeline: rounding of sums, divider setup, divider stages, final packing.
module qau_div #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qau_pkg::front_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qau_pkg::quat_t       r,
    output logic                 fault
);
    import qau_pkg::*;

    localparam int NUM_W = DATA_W + 2 * FRAC_BITS;

    logic vp_reg, vo_reg, vf_reg;
    logic enp, eno, enf;

    logic                    isdiv_p_next, isdiv_p_reg;
    logic                    fault_p_reg;
    quat_t                   res_p_next, res_p_reg;
    logic [DEN_W-1:0]        den_p_next, den_p_reg;
    logic [NUM_W-1:0]        num_p_next [LANES];
    logic [NUM_W-1:0]        num_p_reg [LANES];
    logic [LANES-1:0]        neg_p_reg;

    div_word_t o_next, o_reg;

    logic      step_v   [QBITS+1];
    logic      step_rdy [QBITS+1];
    div_word_t step_w   [QBITS+1];

    quat_t r_next, r_reg;
    logic  fault_reg;

    assign enf = !vf_reg || out_ready;
    assign eno = !vo_reg || step_rdy[0];
    assign enp = !vp_reg || eno;
    assign in_ready  = enp;
    assign out_valid = vf_reg;
    assign r         = r_reg;
    assign fault     = fault_reg;

    // round products and norm, pick divisor and dividends
    always_comb
    begin
        isdiv_p_next = (in_word.cmd == CMD_DIV) || (in_word.cmd == CMD_RECIP);
        den_p_next   = (in_word.cmd == CMD_DIV) ? DEN_W'(in_word.fmag)
                                                : in_word.acc[0][DEN_W-1:0];
        for (int l = 0; l < LANES; l++)
        begin
            logic [ACC_W-1:0] accm;
            logic [ACC_W-1:0] rnd;
            accm = in_word.acc[l][ACC_W-1] ? (~in_word.acc[l] + 1'b1) : in_word.acc[l];
            rnd  = (accm + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if ((in_word.cmd == CMD_PROD) || (in_word.cmd == CMD_SCALE)
                || (in_word.cmd == CMD_NORM))
                res_p_next[l] = sat_pack(in_word.acc[l][ACC_W-1], rnd);
            else
                res_p_next[l] = in_word.simple[l];
            if (in_word.cmd == CMD_DIV)
                num_p_next[l] = NUM_W'(in_word.mag[l]) << FRAC_BITS;
            else
                num_p_next[l] = NUM_W'(in_word.mag[l]) << (2 * FRAC_BITS);
        end
    end

    // quotient overflow check and initial remainder
    always_comb
    begin
        o_next        = '0;
        o_next.is_div = isdiv_p_reg;
        o_next.fault  = fault_p_reg;
        o_next.res    = res_p_reg;
        o_next.den    = den_p_reg;
        o_next.neg    = neg_p_reg;
        for (int l = 0; l < LANES; l++)
        begin
            logic [DEN_W-1:0] hi;
            hi = DEN_W'(num_p_reg[l] >> QBITS);
            o_next.ovf[l] = hi >= den_p_reg;
            o_next.rem[l] = hi;
            o_next.nq[l]  = num_p_reg[l][QBITS-1:0];
        end
    end

    assign step_v[0] = vo_reg;
    assign step_w[0] = o_reg;
    assign step_rdy[QBITS] = enf;

    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        qau_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_v[k]),
            .in_ready  (step_rdy[k]),
            .in_word   (step_w[k]),
            .out_valid (step_v[k+1]),
            .out_ready (step_rdy[k+1]),
            .out_word  (step_w[k+1])
        );
    end

    // round quotient half away from zero, saturate, merge with other commands
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic             up;
            logic [ACC_W-1:0] m;
            up = {step_w[QBITS].rem[l], 1'b0} >= {1'b0, step_w[QBITS].den};
            m  = step_w[QBITS].ovf[l] ? '1
                                      : (ACC_W'(step_w[QBITS].nq[l]) + ACC_W'(up));
            if (step_w[QBITS].fault)
                r_next[l] = '0;
            else if (step_w[QBITS].is_div)
                r_next[l] = sat_pack(step_w[QBITS].neg[l], m);
            else
                r_next[l] = step_w[QBITS].res[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            if (enp) vp_reg <= in_valid;
            if (eno) vo_reg <= vp_reg;
            if (enf) vf_reg <= step_v[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enp)
        begin
            isdiv_p_reg <= isdiv_p_next;
            fault_p_reg <= in_word.fault;
            res_p_reg   <= res_p_next;
            den_p_reg   <= den_p_next;
            num_p_reg   <= num_p_next;
            neg_p_reg   <= in_word.neg;
        end
        if (eno)
            o_reg <= o_next;
        if (enf)
        begin
            r_reg     <= r_next;
            fault_reg <= step_w[QBITS].fault;
        end
    end

endmodule

>>> tb/quaternion_arithmetic_unit_tb.sv
// Self-checking testbench for the pipelined quaternion arithmetic unit.
module quaternion_arithmetic_unit_tb;
    import qau_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int STALL_MAX = 4000;

    typedef struct {
        logic [3:0] cmd;
        quat_t      a;
        quat_t      b;
        word_t      f;
    } qop_t;

    typedef struct {
        quat_t r;
        logic  flt;
    } qres_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    logic  [3:0] command = '0;
    word_t a_real = '0, a_i = '0, a_j = '0, a_k = '0;
    word_t b_real = '0, b_i = '0, b_j = '0, b_k = '0;
    word_t factor = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t r_real, r_i, r_j, r_k;
    logic  fault;

    qres_t pending_results[$];
    int    mismatches = 0;
    int    results_checked = 0;
    int    items_sent = 0;
    int    faults_seen = 0;
    int    hold_cycles = 0;
    int    stall_count = 0;
    bit    steady = 1'b0;

    quaternion_arithmetic_unit #(.FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command),
        .a_real(a_real), .a_i(a_i), .a_j(a_j), .a_k(a_k),
        .b_real(b_real), .b_i(b_i), .b_j(b_j), .b_k(b_k),
        .factor(factor),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_real(r_real), .r_i(r_i), .r_j(r_j), .r_k(r_k),
        .fault(fault)
    );

    always #2 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic logic [127:0] abs_word(word_t x);
        word_t nx;
        nx = ~x;
        return x[31] ? (128'(nx) + 128'd1) : 128'(x);
    endfunction

    function automatic word_t clamp_pack(logic neg, logic [127:0] m);
        if (!neg)
            return (m > 128'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        return (m > 128'h80000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
    endfunction

    function automatic word_t sat_sum(word_t x, word_t y, logic minus);
        logic signed [33:0] s;
        s = minus ? ($signed({{2{x[31]}}, x}) - $signed({{2{y[31]}}, y}))
                  : ($signed({{2{x[31]}}, x}) + $signed({{2{y[31]}}, y}));
        if (s > 34'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (s < -34'sh80000000) return 32'h80000000;
        return s[31:0];
    endfunction

    function automatic word_t sat_negate(word_t x);
        return (x == 32'h80000000) ? 32'h7FFFFFFF : (~x + 32'd1);
    endfunction

    function automatic logic signed [127:0] wide_mul(word_t x, word_t y);
        logic signed [63:0] p;
        p = $signed(x) * $signed(y);
        return p;
    endfunction

    // exact sum scaled back to Q format, half away from zero
    function automatic word_t round_sum(logic signed [127:0] s);
        logic        neg;
        logic [127:0] m;
        neg = s < 0;
        m = neg ? -s : s;
        m = (m + (128'd1 << (FB - 1))) >> FB;
        return clamp_pack(neg, m);
    endfunction

    function automatic word_t round_quot(logic neg, logic [127:0] num, logic [127:0] den);
        return clamp_pack(neg, ((num << 1) + den) / (den << 1));
    endfunction

    function automatic qres_t predict_quat(qop_t op);
        qres_t        res;
        logic [127:0] nsq;
        res.r = '0;
        res.flt = 1'b0;
        case (op.cmd) inside
            CMD_ADD, CMD_SUB:
                for (int l = 0; l < 4; l++)
                    res.r[l] = sat_sum(op.a[l], op.b[l], op.cmd == CMD_SUB);
            CMD_PROD: begin
                res.r[0] = round_sum(wide_mul(op.a[0], op.b[0]) - wide_mul(op.a[1], op.b[1])
                         - wide_mul(op.a[2], op.b[2]) - wide_mul(op.a[3], op.b[3]));
                res.r[1] = round_sum(wide_mul(op.a[0], op.b[1]) + wide_mul(op.a[1], op.b[0])
                         + wide_mul(op.a[2], op.b[3]) - wide_mul(op.a[3], op.b[2]));
                res.r[2] = round_sum(wide_mul(op.a[0], op.b[2]) - wide_mul(op.a[1], op.b[3])
                         + wide_mul(op.a[2], op.b[0]) + wide_mul(op.a[3], op.b[1]));
                res.r[3] = round_sum(wide_mul(op.a[0], op.b[3]) + wide_mul(op.a[1], op.b[2])
                         - wide_mul(op.a[2], op.b[1]) + wide_mul(op.a[3], op.b[0]));
            end
            CMD_CONJ: begin
                res.r[0] = op.a[0];
                for (int l = 1; l < 4; l++) res.r[l] = sat_negate(op.a[l]);
            end
            CMD_NEG:
                for (int l = 0; l < 4; l++) res.r[l] = sat_negate(op.a[l]);
            CMD_SCALE:
                for (int l = 0; l < 4; l++) res.r[l] = round_sum(wide_mul(op.a[l], op.f));
            CMD_DIV: begin
                if (op.f == '0) res.flt = 1'b1;
                else
                    for (int l = 0; l < 4; l++)
                        res.r[l] = round_quot(op.a[l][31] != op.f[31],
                                              abs_word(op.a[l]) << FB, abs_word(op.f));
            end
            CMD_RECIP: begin
                nsq = '0;
                for (int l = 0; l < 4; l++) nsq += abs_word(op.a[l]) * abs_word(op.a[l]);
                if (nsq == '0) res.flt = 1'b1;
                else
                    for (int l = 0; l < 4; l++)
                        res.r[l] = round_quot((l == 0) ? op.a[l][31]
                                              : (!op.a[l][31] && op.a[l] != '0),
                                              abs_word(op.a[l]) << (2 * FB), nsq);
            end
            CMD_NORM:
                res.r[0] = round_sum(wide_mul(op.a[0], op.a[0]) + wide_mul(op.a[1], op.a[1])
                         + wide_mul(op.a[2], op.a[2]) + wide_mul(op.a[3], op.a[3]));
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- stimulus ----------------
    task automatic send_item(qop_t op);
        // each cycle idles with the same odds, so about a third of cycles are gaps
        while (!steady && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= op.cmd;
        a_real <= op.a[0]; a_i <= op.a[1]; a_j <= op.a[2]; a_k <= op.a[3];
        b_real <= op.b[0]; b_i <= op.b[1]; b_j <= op.b[2]; b_k <= op.b[3];
        factor <= op.f;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        pending_results.push_back(predict_quat(op));
        items_sent++;
        @(posedge clk);
    endtask

    function automatic word_t rand_word();
        word_t corner[6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h1,
                             32'hFFFFFFFF, 32'h00010000};
        case ($urandom_range(0, 5)) inside
            0, 1: return $urandom;
            2:    return corner[$urandom_range(0, 5)];
            3:    return word_t'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
            default: return word_t'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'shFFFFFF);
        endcase
    endfunction

    function automatic qop_t rand_op();
        qop_t op;
        op.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
        for (int l = 0; l < 4; l++) begin
            op.a[l] = rand_word();
            op.b[l] = rand_word();
        end
        op.f = rand_word();
        if (op.cmd == CMD_DIV && $urandom_range(0, 9) == 0) op.f = '0;
        if (op.cmd == CMD_RECIP && $urandom_range(0, 9) == 0) op.a = '0;
        return op;
    endfunction

    function automatic qop_t make_op(logic [3:0] c, word_t a0, word_t a1, word_t a2,
                                     word_t a3, word_t b0, word_t f);
        qop_t op;
        op.cmd = c;
        op.a = {a3, a2, a1, a0};
        op.b = {b0, b0, b0, b0};
        op.f = f;
        return op;
    endfunction

    task automatic test_directed();
        qop_t ops[$];
        ops.push_back(make_op(CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0,
                              32'h7FFFFFFF, 32'h0));
        ops.push_back(make_op(CMD_ADD, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'h5,
                              32'h80000000, 32'h0));
        ops.push_back(make_op(CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1234,
                              32'h7FFFFFFF, 32'h0));
        ops.push_back(make_op(CMD_SUB, 32'h7FFFFFFF, 32'h0, 32'h1, 32'h80000000,
                              32'h80000000, 32'h0));
        ops.push_back(make_op(CMD_PROD, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                              32'h80000000, 32'h80000000, 32'h0));
        ops.push_back(make_op(CMD_PROD, 32'h00010000, 32'h00020000, 32'hFFFF0000,
                              32'h00008000, 32'h00018000, 32'h0));
        ops.push_back(make_op(CMD_CONJ, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h0,
                              32'h0, 32'h0));
        ops.push_back(make_op(CMD_NEG, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF,
                              32'h0, 32'h0));
        ops.push_back(make_op(CMD_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF,
                              32'h0, 32'h7FFFFFFF));
        // ties at half a step, both signs
        ops.push_back(make_op(CMD_SCALE, 32'h1, 32'hFFFFFFFF, 32'h3, 32'hFFFFFFFD,
                              32'h0, 32'h00008000));
        ops.push_back(make_op(CMD_SCALE, 32'h00010000, 32'h80000000, 32'h0, 32'h12345,
                              32'h0, 32'h80000000));
        ops.push_back(make_op(CMD_DIV, 32'h00010000, 32'h7FFFFFFF, 32'h1, 32'h0,
                              32'h0, 32'h0));
        ops.push_back(make_op(CMD_DIV, 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'hFFFFFFFF,
                              32'h0, 32'h1));
        ops.push_back(make_op(CMD_DIV, 32'h00010000, 32'h00030000, 32'hFFFF8000, 32'h1,
                              32'h0, 32'hFFFE0000));
        ops.push_back(make_op(CMD_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1,
                              32'h0, 32'h80000000));
        ops.push_back(make_op(CMD_RECIP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        ops.push_back(make_op(CMD_RECIP, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        ops.push_back(make_op(CMD_RECIP, 32'h1, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0));
        ops.push_back(make_op(CMD_RECIP, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                              32'h80000000, 32'h0, 32'h0));
        ops.push_back(make_op(CMD_RECIP, 32'hFFFF0000, 32'h00010000, 32'hFFFF0000,
                              32'h00020000, 32'h0, 32'h0));
        ops.push_back(make_op(CMD_NORM, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h0, 32'h0));
        ops.push_back(make_op(CMD_NORM, 32'h00010000, 32'hFFFF0000, 32'h0, 32'h1,
                              32'h0, 32'h0));
        ops.push_back(make_op(4'd9, 32'h7FFFFFFF, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0));
        ops.push_back(make_op(4'd15, 32'h80000000, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0));
        foreach (ops[n]) send_item(ops[n]);
    endtask

    task automatic test_random(int count);
        repeat (count) send_item(rand_op());
    endtask

    // receiver stops long enough for the pipeline to fill and drop in_ready
    task automatic test_backpressure();
        hold_cycles = 200;
        steady = 1'b1;
        repeat (80) send_item(rand_op());
        steady = 1'b0;
    endtask

    // ---------------- receiver and checker ----------------
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 32);
    end

    always @(negedge clk) begin
        qres_t want;
        quat_t got;
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count = 0;
        else stall_count++;
        if (stall_count >= STALL_MAX) begin
            $display("timeout: no item moved for %0d cycles", STALL_MAX);
            $display("simulation failed");
            $finish;
        end
        if (rst_n && out_valid && out_ready) begin
            got = {r_k, r_j, r_i, r_real};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item r=%h", got);
            end
            else begin
                want = pending_results.pop_front();
                results_checked++;
                if (fault) faults_seen++;
                if (got !== want.r || fault !== want.flt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp r=%h fault=%b, got r=%h fault=%b",
                                 results_checked, want.r, want.flt, got, fault);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        steady = 1'b1;
        test_random(300);
        steady = 1'b0;
        test_backpressure();
        test_random(550);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0) mismatches++;
        $display("sent %0d items over all nine commands plus unused codes, with corner operands,",
                 items_sent);
        $display("random idling and a long output stall; %0d results checked, %0d faults",
                 results_checked, faults_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
